@@ hw/rtl/fixed_point_sin_cos_tan_degrees_defines.svh @@
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef FIXED_POINT_SIN_COS_TAN_DEGREES_DEFINES_SVH
`define FIXED_POINT_SIN_COS_TAN_DEGREES_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FSCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fsct_pkg.sv @@
// Shared types, constants and the quarter-wave sine table.
// No dependencies.
package fsct_pkg;

  // 15 integer plus 16 fraction quotient bits for divisors of 3 and up.
  localparam int unsigned DivSteps = 31;
  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0001;

  typedef enum logic [1:0] {
    CMD_SIN = 2'd0,
    CMD_COS = 2'd1,
    CMD_TAN = 2'd2,
    CMD_TAN_ALT = 2'd3
  } cmd_t;

  // Metadata that travels with each item through the divider.
  typedef struct packed {
    logic        is_tan;
    logic        negq;
    logic        done;    // result already final (sat, small divisor or non-tangent)
    logic        ovf;
    logic [31:0] res;
  } meta_t;

  // Residue of (signed high byte * 256) mod 360, 9 bits per entry,
  // indexed by the raw high byte of the whole-degree part.
  function automatic logic [256*9-1:0] hi_res_table();
    logic [256*9-1:0] t;
    int v;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      v = ((i >= 128) ? i - 256 : i) * 256;
      v = v % 360;
      if (v < 0) v = v + 360;
      t[i*9 +: 9] = 9'(v);
    end
    return t;
  endfunction

  localparam logic [256*9-1:0] HiResTab = hi_res_table();

  function automatic logic [16:0] qwave(input logic [6:0] d);
    logic [16:0] v;
    case (d)
      7'd0: v = 17'd0;      7'd1: v = 17'd1144;   7'd2: v = 17'd2287;
      7'd3: v = 17'd3430;   7'd4: v = 17'd4572;   7'd5: v = 17'd5712;
      7'd6: v = 17'd6850;   7'd7: v = 17'd7987;   7'd8: v = 17'd9121;
      7'd9: v = 17'd10252;  7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
      7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
      7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
      7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
      7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
      7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
      7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
      7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
      7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
      7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
      7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
      7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
      7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
      7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
      7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
      7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
      7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
      7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
      7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
      7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
      7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
      7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
      7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
      7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
      7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
      7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
      7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/fsct_interp.sv @@
// Table lookup and interpolation: reduced degree and fraction in, sine out.
// Two register stages; depends on fsct_pkg.
module fsct_interp (
  input  logic               clk,
  input  logic               en,
  input  logic [8:0]         deg,    // 0..449
  input  logic [15:0]        frac,
  output logic signed [31:0] val     // valid after both enabled register stages
);

  logic [8:0]  d360;
  logic [6:0]  idx;
  logic [1:0]  quad;
  logic [16:0] lo, hi;
  logic        neg, up;
  logic [16:0] lo_r, diff_r;
  logic [15:0] frac_r;
  logic        neg_r, up_r;
  logic [32:0] prod;
  logic [16:0] step, mag;

  // Quadrant decode and table reads.
  always_comb begin
    d360 = (deg >= 9'd360) ? deg - 9'd360 : deg;
    if (d360 >= 9'd270) begin
      quad = 2'd3; idx = 7'(d360 - 9'd270);
    end else if (d360 >= 9'd180) begin
      quad = 2'd2; idx = 7'(d360 - 9'd180);
    end else if (d360 >= 9'd90) begin
      quad = 2'd1; idx = 7'(d360 - 9'd90);
    end else begin
      quad = 2'd0; idx = 7'(d360);
    end
    if (!quad[0]) begin
      lo = fsct_pkg::qwave(idx);
      hi = fsct_pkg::qwave(idx + 7'd1);
    end else begin
      lo = fsct_pkg::qwave(7'd90 - idx);
      hi = fsct_pkg::qwave(7'd89 - idx);
    end
    neg = quad[1];
    up  = (hi >= lo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo;
      diff_r <= up ? hi - lo : lo - hi;
      frac_r <= frac;
      neg_r  <= neg;
      up_r   <= up;
    end
  end

  // Interpolation step, truncated in magnitude.
  always_comb begin
    prod = diff_r * frac_r;
    step = prod[32:16];
    mag  = up_r ? lo_r + step : lo_r - step;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= neg_r ? -$signed({15'd0, mag}) : $signed({15'd0, mag});
    end
  end

endmodule

@@ hw/rtl/fsct_div_stage.sv @@
// One restoring-division step: one quotient bit per stage.
// Depends on fsct_pkg.
module fsct_div_stage (
  input  logic                clk,
  input  logic                en,
  input  logic [17:0]         rem_in,
  input  logic [16:0]         den_in,
  input  logic [31:0]         q_in,
  input  fsct_pkg::meta_t     meta_in,
  output logic [17:0]         rem_out,
  output logic [16:0]         den_out,
  output logic [31:0]         q_out,
  output fsct_pkg::meta_t     meta_out
);

  logic [18:0] sh;
  logic        ge;

  // Next dividend bit comes off the top of q; quotient bits enter at the bottom.
  always_comb begin
    sh = {rem_in, q_in[31]};
    ge = (sh >= {2'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? 18'(sh - {2'b0, den_in}) : 18'(sh);
      den_out  <= den_in;
      q_out    <= {q_in[30:0], ge};
      meta_out <= meta_in;
    end
  end

endmodule

@@ hw/rtl/fixed_point_sin_cos_tan_degrees.sv @@
// Channel | ports                      | direction
// in      | in_valid in_stall in_cmd in_angle | into block
// out     | out_valid out_stall out_result out_overflow | out of block
// Stages: reduce, 2 interp stages, sign/special cases, divider setup,
// 31 division stages (15 integer, 16 fraction), output.
// One transaction per cycle while the output is not stalled.
// The whole pipe advances when the output register is empty or taken;
// a stall freezes every stage. Synchronous active-low reset clears valids.
// Depends on fsct_pkg, fsct_interp, fsct_div_stage.
module fixed_point_sin_cos_tan_degrees (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_overflow
);

  localparam int unsigned DIV_STEPS = fsct_pkg::DivSteps;
  localparam int unsigned NV = DIV_STEPS + 6;

  logic en;
  logic [NV-1:0] v_r, v_nxt;

  assign en = !(v_r[NV-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = v_r[NV-1];

  always_comb begin
    v_nxt = v_r;
    if (en) v_nxt = {v_r[NV-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= v_nxt;
  end

  // Stage 0: floor whole degrees and reduce modulo 360 (residue table
  // per signed high byte, plus the low byte, one conditional subtract).
  logic [11:0] hb_idx;
  logic [8:0]  deg0_nxt, deg0_r;
  logic [15:0] frac0_r;
  logic [1:0]  cmd0_r;
  always_comb begin
    logic [8:0] rh;
    logic [9:0] s;
    hb_idx = 12'(in_angle[31:24]) * 12'd9;
    rh = fsct_pkg::HiResTab[hb_idx +: 9];
    s = {1'b0, rh} + {2'b0, in_angle[23:16]};
    if (s >= 10'd360) s = s - 10'd360;
    deg0_nxt = s[8:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      deg0_r  <= deg0_nxt;
      frac0_r <= in_angle[15:0];
      cmd0_r  <= in_cmd;
    end
  end

  // Stages 1-2: sine and cosine interpolation in parallel.
  logic signed [31:0] s_val, c_val;
  logic [1:0] cmd1_r, cmd2_r;
  fsct_interp u_sin (.clk, .en, .deg(deg0_r), .frac(frac0_r), .val(s_val));
  fsct_interp u_cos (.clk, .en, .deg(deg0_r + 9'd90), .frac(frac0_r), .val(c_val));
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd0_r;
      cmd2_r <= cmd1_r;
    end
  end

  // Stage 3: magnitudes, signs, special cases.
  fsct_pkg::meta_t m3_r;
  logic [16:0] ua3_r, ub3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ua3_r <= s_val[31] ? 17'(-s_val) : 17'(s_val);
      ub3_r <= c_val[31] ? 17'(-c_val) : 17'(c_val);
      m3_r.is_tan <= cmd2_r[1];
      m3_r.negq <= s_val[31] != c_val[31];
      m3_r.done <= !cmd2_r[1] || (c_val == 0);
      m3_r.ovf  <= cmd2_r[1] && (c_val == 0);
      if (!cmd2_r[1])
        m3_r.res <= cmd2_r[0] ? c_val : s_val;
      else
        m3_r.res <= s_val[31] ? fsct_pkg::SatNeg : fsct_pkg::SatPos;
    end
  end

  // Stage 4: divisors 1 and 2 are finished here by shifting; only they can
  // overflow since |sin| <= 65536. Larger divisors load the long division:
  // the quotient stays below 2^31, so the first two dividend bits seed the
  // remainder and the rest (then 16 zeros) ride in q.
  fsct_pkg::meta_t m4_r, m4_nxt;
  logic [17:0] rem4_r;
  logic [16:0] ub4_r;
  logic [31:0] q4_r;
  logic [31:0] q_sp;
  logic        small_div, ovf_sp;
  always_comb begin
    small_div = (ub3_r <= 17'd2);
    ovf_sp = (ub3_r == 17'd1) ? (ua3_r >= 17'd32768) : (ua3_r == 17'd65536);
    q_sp = (ub3_r == 17'd1) ? {ua3_r[15:0], 16'd0} : {ua3_r, 15'd0};
    m4_nxt = m3_r;
    if (!m3_r.done && small_div) begin
      m4_nxt.done = 1'b1;
      m4_nxt.ovf  = ovf_sp;
      if (ovf_sp)
        m4_nxt.res = m3_r.negq ? fsct_pkg::SatNeg : fsct_pkg::SatPos;
      else
        m4_nxt.res = m3_r.negq ? -q_sp : q_sp;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m4_r   <= m4_nxt;
      ub4_r  <= ub3_r;
      rem4_r <= {16'd0, ua3_r[16:15]};
      q4_r   <= {ua3_r[14:0], 17'd0};
    end
  end

  // Quotient bits: one stage per bit.
  logic [17:0] rem_c [DIV_STEPS+1];
  logic [16:0] den_c [DIV_STEPS+1];
  logic [31:0] q_c [DIV_STEPS+1];
  fsct_pkg::meta_t m_c [DIV_STEPS+1];
  assign rem_c[0] = rem4_r;
  assign den_c[0] = ub4_r;
  assign q_c[0] = q4_r;
  assign m_c[0] = m4_r;
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    fsct_div_stage u_st (
      .clk, .en,
      .rem_in(rem_c[g]), .den_in(den_c[g]), .q_in(q_c[g]), .meta_in(m_c[g]),
      .rem_out(rem_c[g+1]), .den_out(den_c[g+1]), .q_out(q_c[g+1]),
      .meta_out(m_c[g+1])
    );
  end

  // Final sign and output register.
  logic [31:0] qf;
  assign qf = {1'b0, q_c[DIV_STEPS][30:0]};
  always_ff @(posedge clk) begin
    if (en) begin
      if (m_c[DIV_STEPS].done) begin
        out_result   <= m_c[DIV_STEPS].res;
        out_overflow <= m_c[DIV_STEPS].ovf;
      end else begin
        out_result   <= m_c[DIV_STEPS].negq ? -qf : qf;
        out_overflow <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/fsct_checker.sv @@
// Port-level checker for the sine/cosine/tangent block, bound to the top.
// Depends on fixed_point_sin_cos_tan_degrees_defines.svh.
`include "fixed_point_sin_cos_tan_degrees_defines.svh"
module fsct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_result,
  input logic               out_overflow
);
  `FSCT_ASSERT_IMP(a_ovf_sat, out_valid && out_overflow,
    out_result == 32'sh7FFF_FFFF || out_result == 32'sh8000_0001, "overflow not saturated")
  `FSCT_ASSERT_IMP(a_stall_link, in_stall, out_valid && out_stall, "input stalled without cause")
  `FSCT_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(out_result) && $stable(out_overflow), "stalled result moved")
endmodule

bind fixed_point_sin_cos_tan_degrees fsct_checker u_fsct_checker (.*);
